FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define CWC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked on every rising clock edge, during reset as well.
`define CWC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: rtl/cwc_pkg.sv
// Shared constants, types and arithmetic helpers of the wall collision block.
`default_nettype none

package cwc_pkg;

    localparam int CWC_MAX_WALLS   = 16;
    localparam int CWC_ADDR_W      = $clog2(CWC_MAX_WALLS);
    localparam int CWC_CNT_W       = CWC_ADDR_W + 1;
    localparam int CWC_ENTRY_W     = 96;
    localparam int CWC_Q_W         = 35;
    localparam int CWC_SQRT_STEPS  = 32;
    localparam int CWC_STEP_W      = 6;
    localparam logic CWC_REG_WALL_COUNT = 1'b0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_WRITE,
        OP_LOAD,
        OP_RD_C,
        OP_EDGE,
        OP_WX,
        OP_WY,
        OP_SQ1,
        OP_SQ2,
        OP_SQRT,
        OP_CR1,
        OP_CR2,
        OP_DIV,
        OP_DIST,
        OP_DOT2,
        OP_WL,
        OP_TX,
        OP_TY,
        OP_RESULT
    } t_dp_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK,
        S_RDI,
        S_RDC,
        S_EDGE,
        S_WX,
        S_WY,
        S_SQ1,
        S_SQ2,
        S_SQRT,
        S_CR1,
        S_CR2,
        S_DIV1,
        S_DIST,
        S_DOT2,
        S_DIV2,
        S_WL,
        S_TX,
        S_TY,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic               operation;
        logic [3:0]         wall_index;
        logic signed [31:0] wall_x;
        logic signed [31:0] wall_z;
        logic signed [15:0] wall_normal_x;
        logic signed [15:0] wall_normal_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        radius;
    } t_in_item;

    typedef struct packed {
        t_dp_op                op;
        logic [CWC_ADDR_W-1:0] rd_addr;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic dist_neg;
        logic wl_ok;
    } t_sts;

    // Shift right by 14, rounding half away from zero.
    function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        begin
            m = v[63] ? 64'(-v) : 64'(v);
            r = (m + 64'd8192) >> 14;
            rnd14 = v[63] ? -$signed(r) : $signed(r);
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) begin
                sat32 = 32'sh7fffffff;
            end else if (v < -64'sd2147483648) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

    // Symmetric clamp to plus or minus (2^31 - 1).
    function automatic logic signed [31:0] symsat(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647) begin
                symsat = 32'sh7fffffff;
            end else if (v < -64'sd2147483647) begin
                symsat = 32'sh80000001;
            end else begin
                symsat = v[31:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/cwc_if.sv
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none

interface cwc_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [3:0]         wall_index;
    logic signed [31:0] wall_x;
    logic signed [31:0] wall_z;
    logic signed [15:0] wall_normal_x;
    logic signed [15:0] wall_normal_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        radius;

    modport source (
        output valid, operation, wall_index, wall_x, wall_z, wall_normal_x,
               wall_normal_z, pos_x, pos_y, vel_x, vel_y, radius,
        input  ready
    );
    modport sink (
        input  valid, operation, wall_index, wall_x, wall_z, wall_normal_x,
               wall_normal_z, pos_x, pos_y, vel_x, vel_y, radius,
        output ready
    );
endinterface

interface cwc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_vx;
    logic signed [31:0] new_vy;

    modport source (output valid, new_x, new_y, new_vx, new_vy, input ready);
    modport sink (input valid, new_x, new_y, new_vx, new_vy, output ready);
endinterface

`default_nettype wire

FILE: rtl/circle_wall_collision_push_back.sv
// Top level of the circle against polygon wall collision block.
//
//   Channel  Direction  Handshake          Transfer contents
//   i_in     input      valid / ready      table write or move request
//   o_out    output     valid / ready      corrected position and velocity
//   APB      input      psel/penable/...   wall_count register at address 0
//
// A table write is taken in the idle state. A move visits each wall in use: it
// skips a wall whose edge has zero length, stops after the signed distance when
// that is not negative, and else goes on to the wall-length check and the push.
// Each non-zero edge runs the 32-step bit-serial square root and the shared
// 35-step bit-serial divider, which runs again for a negative distance.
// Reset is synchronous and active low; it clears the controller, the result
// valid flag and sets wall_count to 4. The wall table is not cleared.
// A finished result sits in the output register until it is taken; the block
// keeps accepting transfers meanwhile and only stalls a later move at its end.
`default_nettype none

module circle_wall_collision_push_back (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cwc_in_if.sink     i_in,
    cwc_out_if.source  o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [4:0]                    r_wall_count;
    logic [cwc_pkg::CWC_CNT_W-1:0] w_n_walls;
    cwc_pkg::t_in_item             w_item;
    cwc_pkg::t_cmd                 w_cmd;
    cwc_pkg::t_sts                 w_sts;

    // The configuration port never stalls; the register decodes on bit 2 only.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == cwc_pkg::CWC_REG_WALL_COUNT) ? {27'b0, r_wall_count}
                                                              : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_count <= 5'd4;
        end else if (psel && penable && pwrite
                     && (paddr[2] == cwc_pkg::CWC_REG_WALL_COUNT)) begin
            r_wall_count <= pwdata[4:0];
        end
    end

    // Counts above the table depth use the whole table.
    assign w_n_walls = (32'(r_wall_count) > cwc_pkg::CWC_MAX_WALLS)
                     ? (cwc_pkg::CWC_CNT_W)'(cwc_pkg::CWC_MAX_WALLS)
                     : (cwc_pkg::CWC_CNT_W)'(r_wall_count);

    assign w_item.operation     = i_in.operation;
    assign w_item.wall_index    = i_in.wall_index;
    assign w_item.wall_x        = i_in.wall_x;
    assign w_item.wall_z        = i_in.wall_z;
    assign w_item.wall_normal_x = i_in.wall_normal_x;
    assign w_item.wall_normal_z = i_in.wall_normal_z;
    assign w_item.pos_x         = i_in.pos_x;
    assign w_item.pos_y         = i_in.pos_y;
    assign w_item.vel_x         = i_in.vel_x;
    assign w_item.vel_y         = i_in.vel_y;
    assign w_item.radius        = i_in.radius;

    cwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.operation),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_n_walls   (w_n_walls),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    cwc_dp u_dp (
        .i_clk    (i_clk),
        .i_item   (w_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_new_x  (o_out.new_x),
        .o_new_y  (o_out.new_y),
        .o_new_vx (o_out.new_vx),
        .o_new_vy (o_out.new_vy)
    );

endmodule

`default_nettype wire

FILE: rtl/cwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/cwc_ctrl.sv
// Controller state machine that sequences table writes and the per-wall steps.
`default_nettype none

module cwc_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_op,
    output logic                               o_in_ready,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [cwc_pkg::CWC_CNT_W-1:0] i_n_walls,
    input  wire cwc_pkg::t_sts                 i_sts,
    output cwc_pkg::t_cmd                      o_cmd
);

    cwc_pkg::t_state                   r_state, n_state;
    logic [cwc_pkg::CWC_CNT_W-1:0]     r_i, n_i;
    logic [cwc_pkg::CWC_STEP_W-1:0]    r_cnt, n_cnt;
    logic                              r_out_valid, n_out_valid;
    logic [cwc_pkg::CWC_CNT_W-1:0]     w_inc;
    logic [cwc_pkg::CWC_CNT_W-1:0]     w_next;

    assign w_inc  = r_i + (cwc_pkg::CWC_CNT_W)'(1);
    assign w_next = (w_inc == i_n_walls) ? '0 : w_inc;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwc_pkg::S_IDLE;
            r_i         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_i           = r_i;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_in_ready    = 1'b0;
        o_cmd.op      = cwc_pkg::OP_NONE;
        o_cmd.rd_addr = r_i[cwc_pkg::CWC_ADDR_W-1:0];
        unique case (r_state)
            cwc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op) begin
                        o_cmd.op = cwc_pkg::OP_LOAD;
                        n_i      = '0;
                        n_state  = cwc_pkg::S_CHK;
                    end else begin
                        o_cmd.op = cwc_pkg::OP_WRITE;
                    end
                end
            end
            cwc_pkg::S_CHK: begin
                n_state = (r_i == i_n_walls) ? cwc_pkg::S_DONE : cwc_pkg::S_RDI;
            end
            cwc_pkg::S_RDI: begin
                n_state = cwc_pkg::S_RDC;
            end
            cwc_pkg::S_RDC: begin
                o_cmd.op      = cwc_pkg::OP_RD_C;
                o_cmd.rd_addr = w_next[cwc_pkg::CWC_ADDR_W-1:0];
                n_state       = cwc_pkg::S_EDGE;
            end
            cwc_pkg::S_EDGE: begin
                o_cmd.op = cwc_pkg::OP_EDGE;
                n_state  = cwc_pkg::S_WX;
            end
            cwc_pkg::S_WX: begin
                if (i_sts.skip) begin
                    n_state = cwc_pkg::S_NEXT;
                end else begin
                    o_cmd.op = cwc_pkg::OP_WX;
                    n_state  = cwc_pkg::S_WY;
                end
            end
            cwc_pkg::S_WY: begin
                o_cmd.op = cwc_pkg::OP_WY;
                n_state  = cwc_pkg::S_SQ1;
            end
            cwc_pkg::S_SQ1: begin
                o_cmd.op = cwc_pkg::OP_SQ1;
                n_state  = cwc_pkg::S_SQ2;
            end
            cwc_pkg::S_SQ2: begin
                o_cmd.op = cwc_pkg::OP_SQ2;
                n_cnt    = '0;
                n_state  = cwc_pkg::S_SQRT;
            end
            cwc_pkg::S_SQRT: begin
                o_cmd.op = cwc_pkg::OP_SQRT;
                if (r_cnt == (cwc_pkg::CWC_STEP_W)'(cwc_pkg::CWC_SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = cwc_pkg::S_CR1;
                end else begin
                    n_cnt = r_cnt + (cwc_pkg::CWC_STEP_W)'(1);
                end
            end
            cwc_pkg::S_CR1: begin
                o_cmd.op = cwc_pkg::OP_CR1;
                n_state  = cwc_pkg::S_CR2;
            end
            cwc_pkg::S_CR2: begin
                o_cmd.op = cwc_pkg::OP_CR2;
                n_cnt    = '0;
                n_state  = cwc_pkg::S_DIV1;
            end
            cwc_pkg::S_DIV1, cwc_pkg::S_DIV2: begin
                o_cmd.op = cwc_pkg::OP_DIV;
                if (r_cnt == (cwc_pkg::CWC_STEP_W)'(cwc_pkg::CWC_Q_W - 1)) begin
                    n_cnt   = '0;
                    n_state = (r_state == cwc_pkg::S_DIV1) ? cwc_pkg::S_DIST
                                                           : cwc_pkg::S_WL;
                end else begin
                    n_cnt = r_cnt + (cwc_pkg::CWC_STEP_W)'(1);
                end
            end
            cwc_pkg::S_DIST: begin
                o_cmd.op = cwc_pkg::OP_DIST;
                n_state  = cwc_pkg::S_DOT2;
            end
            cwc_pkg::S_DOT2: begin
                if (i_sts.dist_neg) begin
                    o_cmd.op = cwc_pkg::OP_DOT2;
                    n_cnt    = '0;
                    n_state  = cwc_pkg::S_DIV2;
                end else begin
                    n_state = cwc_pkg::S_NEXT;
                end
            end
            cwc_pkg::S_WL: begin
                o_cmd.op = cwc_pkg::OP_WL;
                n_state  = i_sts.wl_ok ? cwc_pkg::S_TX : cwc_pkg::S_NEXT;
            end
            cwc_pkg::S_TX: begin
                o_cmd.op = cwc_pkg::OP_TX;
                n_state  = cwc_pkg::S_TY;
            end
            cwc_pkg::S_TY: begin
                o_cmd.op = cwc_pkg::OP_TY;
                n_state  = cwc_pkg::S_NEXT;
            end
            cwc_pkg::S_NEXT: begin
                n_i     = w_inc;
                n_state = cwc_pkg::S_CHK;
            end
            cwc_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = cwc_pkg::OP_RESULT;
                    n_out_valid = 1'b1;
                    n_state     = cwc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cwc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/cwc_dp.sv
// Datapath: wall table, shared multiplier, bit-serial square root and divider.
`default_nettype none

module cwc_dp (
    input  wire logic              i_clk,
    input  wire cwc_pkg::t_in_item i_item,
    input  wire cwc_pkg::t_cmd     i_cmd,
    output cwc_pkg::t_sts          o_sts,
    output logic signed [31:0]     o_new_x,
    output logic signed [31:0]     o_new_y,
    output logic signed [31:0]     o_new_vx,
    output logic signed [31:0]     o_new_vy
);

    localparam int QW = cwc_pkg::CWC_Q_W;

    logic signed [31:0] r_x, r_y, r_vx, r_vy;
    logic [30:0]        r_rad;
    logic signed [31:0] r_px, r_pz;
    logic signed [16:0] r_nx, r_ny;
    logic signed [31:0] r_dwx, r_dwy, r_wx, r_wy;
    logic signed [63:0] r_prod, r_acc;
    logic [63:0]        r_sq_rem, r_root, r_bit;
    logic [32:0]        r_drem;
    logic [QW-1:0]      r_dq;
    logic               r_neg;
    logic signed [QW-1:0] r_dist;

    logic                                  w_we;
    logic [cwc_pkg::CWC_ENTRY_W-1:0]       w_wdata, w_rdata;
    logic signed [34:0]                    w_mul_a;
    logic signed [32:0]                    w_mul_b;
    logic signed [67:0]                    w_mul_p;
    logic                                  w_mul_en;
    logic signed [31:0]                    w_tab_x, w_tab_z;
    logic [31:0]                           w_len;
    logic [63:0]                           w_trial;
    logic [32:0]                           w_dtmp;
    logic                                  w_dge;
    logic signed [QW-1:0]                  w_qs;
    logic signed [63:0]                    w_num;
    logic [63:0]                           w_mag;
    logic signed [63:0]                    w_rp;

    assign w_we = (i_cmd.op == cwc_pkg::OP_WRITE)
               && (32'(i_item.wall_index) < cwc_pkg::CWC_MAX_WALLS);
    assign w_wdata = {i_item.wall_x, i_item.wall_z,
                      i_item.wall_normal_x, i_item.wall_normal_z};

    cwc_ram #(
        .WIDTH (cwc_pkg::CWC_ENTRY_W),
        .DEPTH (cwc_pkg::CWC_MAX_WALLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_item.wall_index[cwc_pkg::CWC_ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_tab_x = w_rdata[95:64];
    assign w_tab_z = w_rdata[63:32];
    assign w_len   = r_root[31:0];
    assign w_trial = r_root + r_bit;
    assign w_dtmp  = {r_drem[31:0], r_dq[QW-1]};
    assign w_dge   = w_dtmp >= {1'b0, w_len};
    assign w_qs    = r_neg ? -$signed(r_dq) : $signed(r_dq);
    assign w_num   = (i_cmd.op == cwc_pkg::OP_CR2) ? (r_acc - r_prod) : (r_acc + r_prod);
    assign w_mag   = w_num[63] ? 64'(-w_num) : 64'(w_num);
    assign w_rp    = cwc_pkg::rnd14(r_prod);

    // Operand selection for the one shared multiplier.
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = '0;
        w_mul_b  = '0;
        unique case (i_cmd.op)
            cwc_pkg::OP_EDGE: begin
                w_mul_a = 35'(r_nx);
                w_mul_b = $signed({2'b00, r_rad});
            end
            cwc_pkg::OP_WX: begin
                w_mul_a = 35'(r_ny);
                w_mul_b = $signed({2'b00, r_rad});
            end
            cwc_pkg::OP_WY: begin
                w_mul_a = 35'(r_dwx);
                w_mul_b = 33'(r_dwx);
            end
            cwc_pkg::OP_SQ1: begin
                w_mul_a = 35'(r_dwy);
                w_mul_b = 33'(r_dwy);
            end
            cwc_pkg::OP_SQ2: begin
                w_mul_a = 35'(r_wx);
                w_mul_b = 33'(r_dwy);
            end
            cwc_pkg::OP_CR1: begin
                w_mul_a = 35'(r_dwx);
                w_mul_b = 33'(r_wy);
            end
            cwc_pkg::OP_CR2: begin
                w_mul_a = 35'(r_wx);
                w_mul_b = 33'(r_dwx);
            end
            cwc_pkg::OP_DIST: begin
                w_mul_a = 35'(r_wy);
                w_mul_b = 33'(r_dwy);
            end
            cwc_pkg::OP_WL: begin
                w_mul_a = r_dist;
                w_mul_b = 33'(r_nx);
            end
            cwc_pkg::OP_TX: begin
                w_mul_a = r_dist;
                w_mul_b = 33'(r_ny);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_mul_p[63:0];
        end
        unique case (i_cmd.op)
            cwc_pkg::OP_LOAD: begin
                r_x   <= cwc_pkg::sat32(64'(i_item.pos_x) + 64'(i_item.vel_x));
                r_y   <= cwc_pkg::sat32(64'(i_item.pos_y) + 64'(i_item.vel_y));
                r_vx  <= i_item.vel_x;
                r_vy  <= i_item.vel_y;
                r_rad <= i_item.radius;
            end
            cwc_pkg::OP_RD_C: begin
                r_px <= w_tab_x;
                r_pz <= w_tab_z;
                r_nx <= -$signed({w_rdata[31], w_rdata[31:16]});
                r_ny <= $signed({w_rdata[15], w_rdata[15:0]});
            end
            cwc_pkg::OP_EDGE: begin
                r_dwx <= cwc_pkg::symsat(64'(w_tab_x) - 64'(r_px));
                r_dwy <= cwc_pkg::symsat(64'(w_tab_z) - 64'(r_pz));
            end
            cwc_pkg::OP_WX: begin
                r_wx <= cwc_pkg::symsat(64'(r_x) - 64'(r_px) + w_rp);
            end
            cwc_pkg::OP_WY: begin
                r_wy <= cwc_pkg::symsat(64'(r_y) - 64'(r_pz) + w_rp);
            end
            cwc_pkg::OP_SQ1, cwc_pkg::OP_CR1: begin
                r_acc <= r_prod;
            end
            cwc_pkg::OP_SQ2: begin
                r_sq_rem <= 64'(r_acc) + 64'(r_prod);
                r_root   <= '0;
                r_bit    <= 64'h4000_0000_0000_0000;
            end
            cwc_pkg::OP_SQRT: begin
                if (r_sq_rem >= w_trial) begin
                    r_sq_rem <= r_sq_rem - w_trial;
                    r_root   <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            cwc_pkg::OP_CR2, cwc_pkg::OP_DOT2: begin
                // Quotients stay below 2^35, so the top dividend bits start
                // out as the partial remainder.
                r_neg  <= w_num[63];
                r_drem <= 33'(w_mag[63:QW]);
                r_dq   <= w_mag[QW-1:0];
            end
            cwc_pkg::OP_DIV: begin
                r_drem <= w_dge ? (w_dtmp - {1'b0, w_len}) : w_dtmp;
                r_dq   <= {r_dq[QW-2:0], w_dge};
            end
            cwc_pkg::OP_DIST: begin
                r_dist <= w_qs;
                r_acc  <= r_prod;
            end
            cwc_pkg::OP_TX: begin
                r_x  <= cwc_pkg::sat32(64'(r_x) + w_rp);
                r_vx <= cwc_pkg::sat32(64'(r_vx) + (w_rp <<< 1));
            end
            cwc_pkg::OP_TY: begin
                r_y  <= cwc_pkg::sat32(64'(r_y) + w_rp);
                r_vy <= cwc_pkg::sat32(64'(r_vy) + (w_rp <<< 1));
            end
            cwc_pkg::OP_RESULT: begin
                o_new_x  <= r_x;
                o_new_y  <= r_y;
                o_new_vx <= r_vx;
                o_new_vy <= r_vy;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.skip     = (r_dwx == '0) && (r_dwy == '0);
    assign o_sts.dist_neg = r_dist[QW-1];
    assign o_sts.wl_ok    = !w_qs[QW-1] && (w_qs <= $signed(QW'(w_len)));

endmodule

`default_nettype wire

FILE: rtl/cwc_checker.sv
// Port-level checker for the wall collision block, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module cwc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_op,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    `CWC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `CWC_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_out_valid)
    `CWC_ASSERT(a_move_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_op |=> !i_in_ready)
    `CWC_ASSERT(a_write_quiet, i_clk, i_rst_n, i_in_valid && i_in_ready && !i_in_op && !i_out_valid |=> !i_out_valid)

endmodule

bind circle_wall_collision_push_back cwc_checker u_cwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_op     (i_in.operation),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);

`default_nettype wire

FILE: bench/circle_wall_collision_push_back_test.sv
// Self-checking testbench for the circle against polygon wall collision block.
`default_nettype none

module circle_wall_collision_push_back_test;

    // Operation codes carried by the operation field of an input transfer.
    localparam logic WALL_WRITE = 1'b0;
    localparam logic MOVE_STEP  = 1'b1;
    localparam int   TABLE_DEPTH = cwc_pkg::CWC_MAX_WALLS;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    // Final wait; it covers the longest move and any tail.
    localparam int SETTLE_CYCLES = 2500;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } motion_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cwc_in_if  in_ch ();
    cwc_out_if out_ch ();

    circle_wall_collision_push_back dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block's wall table and wall count register.
    longint vertex_x[TABLE_DEPTH];
    longint vertex_z[TABLE_DEPTH];
    longint normal_x[TABLE_DEPTH];
    longint normal_z[TABLE_DEPTH];
    int     wall_count_shadow;

    cwc_pkg::t_in_item pending_items[$];
    motion_t           expected_motion[$];
    int error_count;
    int tx_idle_pct;
    int rx_idle_pct;
    int moves_checked;
    int collisions_seen;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Shift right by 14 with rounding half away from zero.
    function automatic longint round_q14(longint v);
        if (v >= 0) begin
            return (v + 8192) >>> 14;
        end
        return -((-v + 8192) >>> 14);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bit_w;
        rem = v;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > rem) bit_w >>= 2;
        while (bit_w != 0) begin
            if (rem >= root + bit_w) begin
                rem -= root + bit_w;
                root = (root >> 1) + bit_w;
            end else begin
                root >>= 1;
            end
            bit_w >>= 2;
        end
        return root;
    endfunction

    // Moves the body, then pushes it out of every wall it penetrates, in table order.
    function automatic motion_t push_back(cwc_pkg::t_in_item it);
        longint x, y, vx, vy, rad, nx, ny, wx, wy, dwx, dwy, len, gap, wl, tx, ty;
        longint unsigned sq;
        int n, c;
        motion_t m;
        vx  = it.vel_x;
        vy  = it.vel_y;
        x   = clip(longint'(it.pos_x) + vx, POS_MIN, POS_MAX);
        y   = clip(longint'(it.pos_y) + vy, POS_MIN, POS_MAX);
        rad = longint'({1'b0, it.radius});
        n   = wall_count_shadow > TABLE_DEPTH ? TABLE_DEPTH : wall_count_shadow;
        for (int i = 0; i < n; i++) begin
            c   = (i + 1) % n;
            nx  = -normal_x[i];
            ny  = normal_z[i];
            wx  = clip(x - vertex_x[i] + round_q14(nx * rad), -POS_MAX, POS_MAX);
            wy  = clip(y - vertex_z[i] + round_q14(ny * rad), -POS_MAX, POS_MAX);
            dwx = clip(vertex_x[c] - vertex_x[i], -POS_MAX, POS_MAX);
            dwy = clip(vertex_z[c] - vertex_z[i], -POS_MAX, POS_MAX);
            if (dwx == 0 && dwy == 0) continue;
            sq   = longint'(dwx * dwx) + longint'(dwy * dwy);
            len  = int_sqrt(sq);
            gap  = (wx * dwy - dwx * wy) / len;
            if (gap < 0) begin
                wl = (wx * dwx + wy * dwy) / len;
                if (wl >= 0 && wl <= len) begin
                    tx = round_q14(gap * nx);
                    ty = round_q14(gap * ny);
                    x  = clip(x + tx, POS_MIN, POS_MAX);
                    y  = clip(y + ty, POS_MIN, POS_MAX);
                    vx = clip(vx + 2 * tx, POS_MIN, POS_MAX);
                    vy = clip(vy + 2 * ty, POS_MIN, POS_MAX);
                    collisions_seen++;
                end
            end
        end
        m.x  = x[31:0];
        m.y  = y[31:0];
        m.vx = vx[31:0];
        m.vy = vy[31:0];
        return m;
    endfunction

    // Driver: presents the oldest pending item, holding it until its transfer.
    always @(posedge i_clk) begin
        cwc_pkg::t_in_item it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                it = pending_items.pop_front();
                if (it.operation == WALL_WRITE) begin
                    vertex_x[it.wall_index] = it.wall_x;
                    vertex_z[it.wall_index] = it.wall_z;
                    normal_x[it.wall_index] = it.wall_normal_x;
                    normal_z[it.wall_index] = it.wall_normal_z;
                end else begin
                    expected_motion.push_back(push_back(it));
                end
            end
            if (in_ch.valid && !in_ch.ready) begin
                // Hold the current item until it is taken.
            end else if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                it = pending_items[0];
                in_ch.operation     <= it.operation;
                in_ch.wall_index    <= it.wall_index;
                in_ch.wall_x        <= it.wall_x;
                in_ch.wall_z        <= it.wall_z;
                in_ch.wall_normal_x <= it.wall_normal_x;
                in_ch.wall_normal_z <= it.wall_normal_z;
                in_ch.pos_x         <= it.pos_x;
                in_ch.pos_y         <= it.pos_y;
                in_ch.vel_x         <= it.vel_x;
                in_ch.vel_y         <= it.vel_y;
                in_ch.radius        <= it.radius;
                in_ch.valid         <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expected motion.
    always @(posedge i_clk) begin
        motion_t m;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_motion.size() == 0) begin
                    $error("result transfer with no move outstanding");
                    error_count++;
                end else begin
                    m = expected_motion.pop_front();
                    moves_checked++;
                    if (out_ch.new_x !== m.x) begin
                        $error("new_x expected %0d got %0d", m.x, out_ch.new_x);
                        error_count++;
                    end
                    if (out_ch.new_y !== m.y) begin
                        $error("new_y expected %0d got %0d", m.y, out_ch.new_y);
                        error_count++;
                    end
                    if (out_ch.new_vx !== m.vx) begin
                        $error("new_vx expected %0d got %0d", m.vx, out_ch.new_vx);
                        error_count++;
                    end
                    if (out_ch.new_vy !== m.vy) begin
                        $error("new_vy expected %0d got %0d", m.vy, out_ch.new_vy);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic cwc_pkg::t_in_item wall_item(int idx, longint wx, longint wz,
                                                    longint nx, longint nz);
        cwc_pkg::t_in_item it;
        it = '0;
        it.operation     = WALL_WRITE;
        it.wall_index    = idx[3:0];
        it.wall_x        = wx[31:0];
        it.wall_z        = wz[31:0];
        it.wall_normal_x = nx[15:0];
        it.wall_normal_z = nz[15:0];
        // Move fields are don't-care on a write; fill some of them anyway.
        it.pos_x  = $urandom;
        it.vel_y  = $urandom;
        it.radius = 31'($urandom);
        return it;
    endfunction

    function automatic cwc_pkg::t_in_item move_item(longint px, longint py, longint vx,
                                                    longint vy, longint rad);
        cwc_pkg::t_in_item it;
        it = '0;
        it.operation  = MOVE_STEP;
        it.wall_index = 4'($urandom);
        it.wall_x     = $urandom;
        it.pos_x      = px[31:0];
        it.pos_y      = py[31:0];
        it.vel_x      = vx[31:0];
        it.vel_y      = vy[31:0];
        it.radius     = rad[30:0];
        return it;
    endfunction

    function automatic cwc_pkg::t_in_item noise_item();
        cwc_pkg::t_in_item it;
        logic [287:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        it = raw[$bits(cwc_pkg::t_in_item)-1:0];
        // Normals stay within the unit range that the format allows.
        it.wall_normal_x = 16'($urandom_range(32768) - 16384);
        it.wall_normal_z = 16'($urandom_range(32768) - 16384);
        return it;
    endfunction

    // Loads a regular polygon of n vertices into entries 0 .. n-1, with unit
    // normals to each edge whose sign is chosen at random for the polygon.
    function automatic int load_polygon(int n, real rad, real cx, real cz);
        real ang, x0, z0, x1, z1, dx, dz, el, sgn;
        sgn = ($urandom_range(1) == 1) ? 1.0 : -1.0;
        for (int i = 0; i < n; i++) begin
            ang = 6.283185307 * i / n;
            x0 = cx + rad * $cos(ang);
            z0 = cz + rad * $sin(ang);
            ang = 6.283185307 * (i + 1) / n;
            x1 = cx + rad * $cos(ang);
            z1 = cz + rad * $sin(ang);
            dx = x1 - x0;
            dz = z1 - z0;
            el = $sqrt(dx * dx + dz * dz);
            pending_items.push_back(wall_item(i, $rtoi(x0), $rtoi(z0),
                $rtoi(sgn * 16384.0 * dz / el), $rtoi(-sgn * 16384.0 * dx / el)));
        end
        return n;
    endfunction

    task automatic write_wall_count(int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {2'b00, cwc_pkg::CWC_REG_WALL_COUNT};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        wall_count_shadow = value & 31;
    endtask

    // Blocks until every queued item has been taken and every result checked,
    // then lets the block settle so a register write finds it idle.
    task automatic drain();
        while (pending_items.size() > 0 || in_ch.valid || expected_motion.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
    endtask

    // Random part of one register setting: well-formed polygon scenes with
    // bodies placed around the edges, mixed with full-range noise.
    task automatic run_segment(int budget);
        int n, used, moves;
        real rad, cx, cz, ang, r;
        used = 0;
        while (used < budget) begin
            if ($urandom_range(99) < 85) begin
                n   = wall_count_shadow > TABLE_DEPTH ? TABLE_DEPTH : wall_count_shadow;
                if (n < 3) n = 4;
                rad = 65536.0 * $urandom_range(4000, 1);
                cx  = 65536.0 * ($itor($urandom_range(2000)) - 1000.0);
                cz  = 65536.0 * ($itor($urandom_range(2000)) - 1000.0);
                used += load_polygon(n, rad, cx, cz);
                moves = $urandom_range(8, 3);
                for (int k = 0; k < moves; k++) begin
                    ang = 6.283185307 * $urandom_range(9999) / 10000.0;
                    r   = rad * $urandom_range(130, 50) / 100.0;
                    pending_items.push_back(move_item(
                        $rtoi(cx + r * $cos(ang)), $rtoi(cz + r * $sin(ang)),
                        $rtoi(rad * ($itor($urandom_range(200)) - 100.0) / 800.0),
                        $rtoi(rad * ($itor($urandom_range(200)) - 100.0) / 800.0),
                        ($urandom_range(9) == 0) ? 0 : $rtoi(rad * $urandom_range(25) / 100.0)));
                end
                used += moves;
            end else begin
                pending_items.push_back(noise_item());
                used++;
            end
        end
    endtask

    initial begin
        int seg_counts[12];
        int seg;
        seg_counts = '{3, 5, 16, 6, 0, 8, 1, 31, 2, 3, 12, 4};
        error_count = 0;
        moves_checked = 0;
        collisions_seen = 0;
        wall_count_shadow = 4;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.operation = WALL_WRITE;
        in_ch.wall_index = '0;
        in_ch.wall_x = '0;
        in_ch.wall_z = '0;
        in_ch.wall_normal_x = '0;
        in_ch.wall_normal_z = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.vel_x = '0;
        in_ch.vel_y = '0;
        in_ch.radius = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            vertex_x[i] = 0;
            vertex_z[i] = 0;
            normal_x[i] = 0;
            normal_z[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset wall count of four. A square of side
        // 20 units, normals at full scale; entry 4 repeats entry 3 so that a
        // later count of five exposes a zero-length edge. All sixteen entries
        // get written before the first move so nothing undefined is read.
        pending_items.push_back(wall_item(0, -655360, -655360, 0, 16384));
        pending_items.push_back(wall_item(1, 655360, -655360, -16384, 0));
        pending_items.push_back(wall_item(2, 655360, 655360, 0, -16384));
        pending_items.push_back(wall_item(3, -655360, 655360, 16384, 0));
        pending_items.push_back(wall_item(4, -655360, 655360, 16384, 0));
        for (int i = 5; i < TABLE_DEPTH; i++) begin
            pending_items.push_back(wall_item(i, (i % 2) ? POS_MAX : POS_MIN,
                (i % 3) ? POS_MIN : POS_MAX, (i % 2) ? -16384 : 16384, 0));
        end
        pending_items.push_back(move_item(600000, 0, 100000, 0, 65536));
        pending_items.push_back(move_item(0, -600000, 0, -120000, 65536));
        pending_items.push_back(move_item(0, 0, 0, 0, 0));
        pending_items.push_back(move_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, 0));
        pending_items.push_back(move_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN, 64'h7fffffff));
        pending_items.push_back(move_item(POS_MAX, POS_MIN, 1, -1, 64'h7fffffff));
        pending_items.push_back(move_item(-655000, 655000, -30000, 30000, 131072));
        drain();
        write_wall_count(5);
        pending_items.push_back(move_item(-640000, 640000, -30000, 30000, 131072));
        pending_items.push_back(move_item(650000, -650000, 20000, -20000, 200000));
        drain();

        // Three idling patterns, each over several wall counts, extremes included.
        seg = 0;
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 13 : ((phase == 1) ? 60 : 0);
            rx_idle_pct = (phase == 0) ? 60 : ((phase == 1) ? 13 : 0);
            for (int s = 0; s < 4; s++) begin
                write_wall_count(seg_counts[seg]);
                run_segment((seg_counts[seg] >= 16) ? 40 : 80);
                drain();
                seg++;
            end
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Checked %0d moves (%0d wall contacts) over wall counts 0 to 31,",
                 moves_checked, collisions_seen);
        $display("with sender and receiver stalls in both proportions and none.");
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/cwc_pkg.sv
rtl/cwc_if.sv
rtl/cwc_ram.sv
rtl/cwc_ctrl.sv
rtl/cwc_dp.sv
rtl/circle_wall_collision_push_back.sv
rtl/cwc_checker.sv
bench/circle_wall_collision_push_back_test.sv
